FILE: hdl/i2p_pkg.sv
// Package for the infix-to-postfix converter.
// Holds token and result codes and the controller/datapath interface structs.
// Depends on nothing.
package i2p_pkg;

	// Input token kinds.
	localparam logic [2:0] TK_OPERAND  = 3'd0;
	localparam logic [2:0] TK_OPEN     = 3'd1;
	localparam logic [2:0] TK_CLOSE    = 3'd2;
	localparam logic [2:0] TK_OPERATOR = 3'd3;
	localparam logic [2:0] TK_END      = 3'd4;

	// Result kinds.
	localparam logic [1:0] RK_OPERAND  = 2'd0;
	localparam logic [1:0] RK_OPERATOR = 2'd1;
	localparam logic [1:0] RK_ERROR    = 2'd2;
	localparam logic [1:0] RK_END      = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_UNMATCHED_C = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED_O = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

	// Stack entry code for an open parenthesis; operators use codes 0 to 3.
	localparam logic [2:0] PAREN_CODE = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_token;
		logic       push;
		logic       push_paren;
		logic       pop;
		logic       emit;
		logic [1:0] res_kind;
		logic [1:0] res_err;
		logic       res_last;
	} i2p_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] kind;
		logic       count_zero;
		logic       full;
		logic       top_is_paren;
		logic       next_is_paren;
		logic       top_prec_ge;
		logic       next_stays;
		logic       out_free;
	} i2p_sts_t;

endpackage

FILE: hdl/i2p_dp.sv
// Datapath of the infix-to-postfix converter: token register, operator stack
// memory with two registered read ports, stack count and output register.
// Depends on i2p_pkg.
module i2p_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2p_pkg::i2p_cmd_t cmd,
	output i2p_pkg::i2p_sts_t sts,
	input  logic [2:0]        token_kind,
	input  logic [15:0]       operand_value,
	input  logic [1:0]        operator_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [15:0]       out_value,
	output logic [1:0]        out_operator,
	output logic [1:0]        error_code,
	output logic              last_of_run
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [2:0]    tok_kind_q;
	logic [15:0]   tok_value_q;
	logic [1:0]    tok_code_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [2:0]    stack_mem [STACK_DEPTH];
	logic [2:0]    top_q;
	logic [2:0]    next_q;
	logic [2:0]    push_val;
	logic          out_valid_q;

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign push_val = cmd.push_paren ? i2p_pkg::PAREN_CODE : {1'b0, tok_code_q};

	// Token register.
	always_ff @(posedge clk) begin
		if (cmd.load_token) begin
			tok_kind_q  <= token_kind;
			tok_value_q <= operand_value;
			tok_code_q  <= operator_code;
		end
	end

	// Stack count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	// Stack memory: one write port, top and second entries read every cycle.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[count_q[AW-1:0]] <= push_val;
		end
		top_q  <= stack_mem[cnt_m1[AW-1:0]];
		next_q <= stack_mem[cnt_m2[AW-1:0]];
	end

	// Output register; a beat leaves when out_ready is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind     <= cmd.res_kind;
			out_value    <= (cmd.res_kind == i2p_pkg::RK_OPERAND) ? tok_value_q : 16'd0;
			out_operator <= (cmd.res_kind == i2p_pkg::RK_OPERATOR) ? top_q[1:0] : 2'd0;
			error_code   <= cmd.res_err;
			last_of_run  <= cmd.res_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the controller.
	always_comb begin
		sts.kind          = tok_kind_q;
		sts.count_zero    = (count_q == '0);
		sts.full          = (count_q == CW'(STACK_DEPTH));
		sts.top_is_paren  = (top_q == i2p_pkg::PAREN_CODE);
		sts.next_is_paren = (count_q >= CW'(2)) && (next_q == i2p_pkg::PAREN_CODE);
		sts.top_prec_ge   = (top_q[1] >= tok_code_q[1]);
		// The entry below the top is missing, an open parenthesis or of lower precedence.
		sts.next_stays    = (count_q < CW'(2)) || (next_q == i2p_pkg::PAREN_CODE)
			|| (next_q[1] < tok_code_q[1]);
		sts.out_free      = !out_valid_q || out_ready;
	end

endmodule

FILE: hdl/i2p_ctrl.sv
// Controller of the infix-to-postfix converter: accepts tokens and steps the
// stack pushes, pops and result beats of each one.
// Depends on i2p_pkg.
module i2p_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  i2p_pkg::i2p_sts_t sts,
	output i2p_pkg::i2p_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_token = 1'b1;
					state_d        = ST_EVAL;
				end
			end
			ST_WAIT: begin
				// The read ports catch up with the new count.
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				unique case (sts.kind)
					i2p_pkg::TK_OPERAND: begin
						if (sts.out_free) begin
							cmd.emit     = 1'b1;
							cmd.res_kind = i2p_pkg::RK_OPERAND;
							cmd.res_last = 1'b1;
							state_d      = ST_IDLE;
						end
					end
					i2p_pkg::TK_OPEN: begin
						if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit     = 1'b1;
								cmd.res_kind = i2p_pkg::RK_ERROR;
								cmd.res_err  = i2p_pkg::ERR_OVERFLOW;
								cmd.res_last = 1'b1;
								state_d      = ST_IDLE;
							end
						end else begin
							cmd.push       = 1'b1;
							cmd.push_paren = 1'b1;
							state_d        = ST_IDLE;
						end
					end
					i2p_pkg::TK_CLOSE: begin
						if (sts.count_zero) begin
							if (sts.out_free) begin
								cmd.emit     = 1'b1;
								cmd.res_kind = i2p_pkg::RK_ERROR;
								cmd.res_err  = i2p_pkg::ERR_UNMATCHED_C;
								cmd.res_last = 1'b1;
								state_d      = ST_IDLE;
							end
						end else if (sts.top_is_paren) begin
							// Matching parenthesis is dropped silently.
							cmd.pop = 1'b1;
							state_d = ST_IDLE;
						end else if (sts.out_free) begin
							// Last beat when the match sits right below.
							cmd.emit     = 1'b1;
							cmd.pop      = 1'b1;
							cmd.res_kind = i2p_pkg::RK_OPERATOR;
							cmd.res_last = sts.next_is_paren;
							state_d      = ST_WAIT;
						end
					end
					i2p_pkg::TK_OPERATOR: begin
						if (!sts.count_zero && !sts.top_is_paren && sts.top_prec_ge) begin
							if (sts.out_free) begin
								// Last beat when the entry below will not be popped.
								cmd.emit     = 1'b1;
								cmd.pop      = 1'b1;
								cmd.res_kind = i2p_pkg::RK_OPERATOR;
								cmd.res_last = sts.next_stays;
								state_d      = ST_WAIT;
							end
						end else if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit     = 1'b1;
								cmd.res_kind = i2p_pkg::RK_ERROR;
								cmd.res_err  = i2p_pkg::ERR_OVERFLOW;
								cmd.res_last = 1'b1;
								state_d      = ST_IDLE;
							end
						end else begin
							cmd.push = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					i2p_pkg::TK_END: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							if (sts.count_zero) begin
								cmd.res_kind = i2p_pkg::RK_END;
								cmd.res_last = 1'b1;
								state_d      = ST_IDLE;
							end else begin
								// Flush: leftover open parentheses become errors.
								cmd.pop = 1'b1;
								if (sts.top_is_paren) begin
									cmd.res_kind = i2p_pkg::RK_ERROR;
									cmd.res_err  = i2p_pkg::ERR_UNMATCHED_O;
								end else begin
									cmd.res_kind = i2p_pkg::RK_OPERATOR;
								end
								state_d = ST_WAIT;
							end
						end
					end
					default: begin
						// Unknown kinds are ignored.
						state_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/infix_to_postfix_converter.sv
// Infix-to-postfix converter, shunting-yard scheme, one token per input beat.
// Steps: the token register loads in the idle state, the evaluate state emits into the output register.
// A new token is taken only once the last one is done; each result beat that pops the
// stack passes a wait state, bound by the registered read of the stack memory; dropping the
// matching open parenthesis needs no wait state. Output stalls hold the evaluate state.
// Reset: arst_n clears the stack count, controller state and output valid.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  token_kind,
	input  logic [15:0] operand_value,
	input  logic [1:0]  operator_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [15:0] out_value,
	output logic [1:0]  out_operator,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	i2p_pkg::i2p_cmd_t cmd;
	i2p_pkg::i2p_sts_t sts;

	// Sequencer.
	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stack and result datapath.
	i2p_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.token_kind    (token_kind),
		.operand_value (operand_value),
		.operator_code (operator_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind),
		.out_value     (out_value),
		.out_operator  (out_operator),
		.error_code    (error_code),
		.last_of_run   (last_of_run)
	);

endmodule

FILE: hdl/i2p_checker.sv
// Port-level checker for the infix-to-postfix converter, bound to the top.
// Depends on i2p_pkg and infix_to_postfix_converter.
module i2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [1:0]  out_operator,
	input logic [1:0]  error_code,
	input logic        last_of_run
);

	// A stalled result beat stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// The end result always closes its run.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == i2p_pkg::RK_END |-> last_of_run)
		else $error("end result without last_of_run");

	// Error results carry a code, all others carry none.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_kind == i2p_pkg::RK_ERROR) == (error_code != i2p_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	// Only operator results carry an operator code.
	a_op_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != i2p_pkg::RK_OPERATOR |-> out_operator == 2'd0)
		else $error("operator code on a non-operator result");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_kind     (out_kind),
	.out_operator (out_operator),
	.error_code   (error_code),
	.last_of_run  (last_of_run)
);

FILE: dv/infix_to_postfix_checker.sv
// Checker for the infix-to-postfix converter: watches both channels, predicts postfix beats.
// Holds its own copy of the operator stack and compares each output beat against the oldest
// prediction. Depends on i2p_pkg.
`timescale 1ns / 1ps

module infix_to_postfix_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  token_kind,
	input  logic [15:0] operand_value,
	input  logic [1:0]  operator_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  out_kind,
	input  logic [15:0] out_value,
	input  logic [1:0]  out_operator,
	input  logic [1:0]  error_code,
	input  logic        last_of_run,
	output int          mismatch_count,
	output int          pending_beats,
	output int          token_count,
	output int          beat_count,
	output int          error_beats,
	output int          deepest_stack
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [1:0]  op;
		logic [1:0]  err;
		logic        last;
	} postfix_beat_t;

	// Predicted operator stack: operator codes and the open-parenthesis marker.
	logic [2:0]    op_stack [$];
	postfix_beat_t expected_beats [$];

	initial begin
		mismatch_count = 0;
		pending_beats = 0;
		token_count = 0;
		beat_count = 0;
		error_beats = 0;
		deepest_stack = 0;
	end

	function automatic postfix_beat_t make_beat(input logic [1:0] kind, input logic [15:0] value,
			input logic [1:0] op, input logic [1:0] err);
		postfix_beat_t b;
		b.kind = kind;
		b.value = value;
		b.op = op;
		b.err = err;
		b.last = 1'b0;
		return b;
	endfunction

	// Multiply and divide share the high bit of the operator code, which sets precedence.
	function automatic bit pops_before(input logic [2:0] stacked, input logic [1:0] incoming);
		return stacked != i2p_pkg::PAREN_CODE && stacked[1] >= incoming[1];
	endfunction

	// Runs one token through the shunting-yard step and queues the beats it releases.
	task automatic predict_token(input logic [2:0] kind, input logic [15:0] value,
			input logic [1:0] code);
		postfix_beat_t run [$];
		logic [2:0]    top;
		bit            matched;
		matched = 1'b0;
		case (kind)
			i2p_pkg::TK_OPERAND: begin
				run.push_back(make_beat(i2p_pkg::RK_OPERAND, value, '0, i2p_pkg::ERR_NONE));
			end
			i2p_pkg::TK_OPEN: begin
				if (op_stack.size() >= STACK_DEPTH) begin
					run.push_back(make_beat(i2p_pkg::RK_ERROR, '0, '0, i2p_pkg::ERR_OVERFLOW));
				end else begin
					op_stack.push_back(i2p_pkg::PAREN_CODE);
				end
			end
			i2p_pkg::TK_CLOSE: begin
				while (op_stack.size() > 0 && !matched) begin
					top = op_stack.pop_back();
					if (top == i2p_pkg::PAREN_CODE)
						matched = 1'b1;
					else
						run.push_back(make_beat(i2p_pkg::RK_OPERATOR, '0, top[1:0],
							i2p_pkg::ERR_NONE));
				end
				if (!matched)
					run.push_back(make_beat(i2p_pkg::RK_ERROR, '0, '0,
						i2p_pkg::ERR_UNMATCHED_C));
			end
			i2p_pkg::TK_OPERATOR: begin
				while (op_stack.size() > 0 && pops_before(op_stack[$], code)) begin
					top = op_stack.pop_back();
					run.push_back(make_beat(i2p_pkg::RK_OPERATOR, '0, top[1:0],
						i2p_pkg::ERR_NONE));
				end
				if (op_stack.size() >= STACK_DEPTH) begin
					run.push_back(make_beat(i2p_pkg::RK_ERROR, '0, '0, i2p_pkg::ERR_OVERFLOW));
				end else begin
					op_stack.push_back({1'b0, code});
				end
			end
			i2p_pkg::TK_END: begin
				// Flush from the top; every leftover open parenthesis is an error.
				while (op_stack.size() > 0) begin
					top = op_stack.pop_back();
					if (top == i2p_pkg::PAREN_CODE)
						run.push_back(make_beat(i2p_pkg::RK_ERROR, '0, '0,
							i2p_pkg::ERR_UNMATCHED_O));
					else
						run.push_back(make_beat(i2p_pkg::RK_OPERATOR, '0, top[1:0],
							i2p_pkg::ERR_NONE));
				end
				run.push_back(make_beat(i2p_pkg::RK_END, '0, '0, i2p_pkg::ERR_NONE));
			end
			default: begin
			end
		endcase
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			expected_beats.push_back(run[i]);
		if (op_stack.size() > deepest_stack)
			deepest_stack = op_stack.size();
		token_count++;
	endtask

	// Compares one output beat with the oldest prediction.
	task automatic check_beat();
		postfix_beat_t want;
		beat_count++;
		if (expected_beats.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: unexpected beat: kind %0d value %h op %0d err %0d last %0d",
					$realtime, out_kind, out_value, out_operator, error_code, last_of_run);
		end else begin
			want = expected_beats.pop_front();
			if (out_kind !== want.kind || out_value !== want.value || out_operator !== want.op
					|| error_code !== want.err || last_of_run !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: beat mismatch: expected kind %0d value %h op %0d err %0d last %0d",
						$realtime, want.kind, want.value, want.op, want.err, want.last);
					$display("%0t:                got      kind %0d value %h op %0d err %0d last %0d",
						$realtime, out_kind, out_value, out_operator, error_code, last_of_run);
				end
			end
			if (want.kind == i2p_pkg::RK_ERROR)
				error_beats++;
		end
	endtask

	// Sample both channels at the clock edge, predicting before checking.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_token(token_kind, operand_value, operator_code);
			if (out_valid && out_ready)
				check_beat();
			pending_beats = expected_beats.size();
		end
	end

endmodule

FILE: dv/tb_infix_to_postfix_converter.sv
// Testbench top for the infix-to-postfix converter: clock, reset, token stimulus and verdict.
// Prediction and comparison live in infix_to_postfix_checker. Depends on i2p_pkg and the RTL.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;

	localparam int STACK_DEPTH = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_TOKENS = 12;
	localparam int HOLD_TOKENS = 10;
	localparam int MAX_NESTING = 6;

	// Operator codes as carried on operator_code.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  token_kind;
	logic [15:0] operand_value;
	logic [1:0]  operator_code;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  out_kind;
	logic [15:0] out_value;
	logic [1:0]  out_operator;
	logic [1:0]  error_code;
	logic        last_of_run;

	int mismatch_count;
	int pending_beats;
	int token_count;
	int beat_count;
	int error_beats;
	int deepest_stack;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_armed = 1'b0;

	int sender_idle [4] = '{0, 60, 0, 7};
	int receiver_stall [4] = '{0, 0, 60, 7};

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.token_kind   (token_kind),
		.operand_value(operand_value),
		.operator_code(operator_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.out_operator (out_operator),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

	infix_to_postfix_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token_kind    (token_kind),
		.operand_value (operand_value),
		.operator_code (operator_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind),
		.out_value     (out_value),
		.out_operator  (out_operator),
		.error_code    (error_code),
		.last_of_run   (last_of_run),
		.mismatch_count(mismatch_count),
		.pending_beats (pending_beats),
		.token_count   (token_count),
		.beat_count    (beat_count),
		.error_beats   (error_beats),
		.deepest_stack (deepest_stack)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off when armed.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one token beat after an optional random gap and waits until it is taken.
	task automatic send_token(input logic [2:0] kind, input logic [15:0] value,
			input logic [1:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		token_kind <= kind;
		operand_value <= value;
		operator_code <= code;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Mostly well-formed expressions with random content, some noise and broken endings.
	task automatic send_expressions(input int count);
		int       sent;
		int       depth;
		int       roll;
		bit       want_operand;
		bit [2:0] noise_kind;
		sent = 0;
		depth = 0;
		want_operand = 1'b1;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 12) begin
				noise_kind = 3'($urandom_range(7));
				send_token(noise_kind, 16'($urandom_range(65535)), 2'($urandom_range(3)));
				if (noise_kind <= i2p_pkg::TK_END)
					sent++;
			end else if (want_operand) begin
				if (depth < MAX_NESTING && roll < 35) begin
					send_token(i2p_pkg::TK_OPEN, 16'($urandom_range(65535)),
						2'($urandom_range(3)));
					depth++;
				end else begin
					send_token(i2p_pkg::TK_OPERAND, 16'($urandom_range(65535)),
						2'($urandom_range(3)));
					want_operand = 1'b0;
				end
				sent++;
			end else begin
				if (depth > 0 && roll < 40) begin
					send_token(i2p_pkg::TK_CLOSE, 16'($urandom_range(65535)),
						2'($urandom_range(3)));
					depth--;
				end else if (roll > 90 || (depth == 0 && roll > 78)) begin
					// An end with parentheses still open is a broken expression on purpose.
					send_token(i2p_pkg::TK_END, 16'($urandom_range(65535)),
						2'($urandom_range(3)));
					depth = 0;
					want_operand = 1'b1;
				end else begin
					send_token(i2p_pkg::TK_OPERATOR, 16'($urandom_range(65535)),
						2'($urandom_range(3)));
					want_operand = 1'b1;
				end
				sent++;
			end
		end
		send_token(i2p_pkg::TK_END, 16'($urandom_range(65535)), 2'($urandom_range(3)));
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		token_kind <= i2p_pkg::TK_OPERAND;
		operand_value <= '0;
		operator_code <= OP_ADD;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Close parenthesis on an empty stack.
		send_token(i2p_pkg::TK_CLOSE, 16'h0000, OP_ADD);
		// All four operators, both precedence levels, operand extremes.
		send_token(i2p_pkg::TK_OPERAND, 16'h0000, OP_ADD);
		send_token(i2p_pkg::TK_OPERATOR, 16'hFFFF, OP_SUB);
		send_token(i2p_pkg::TK_OPERAND, 16'hFFFF, OP_ADD);
		send_token(i2p_pkg::TK_OPERATOR, 16'h0000, OP_MUL);
		send_token(i2p_pkg::TK_OPERAND, 16'h1234, OP_DIV);
		send_token(i2p_pkg::TK_OPERATOR, 16'h5A5A, OP_DIV);
		send_token(i2p_pkg::TK_OPERAND, 16'hA5A5, OP_MUL);
		send_token(i2p_pkg::TK_OPERATOR, 16'h0001, OP_ADD);
		send_token(i2p_pkg::TK_OPERAND, 16'h0001, OP_SUB);
		send_token(i2p_pkg::TK_END, 16'hFFFF, OP_DIV);
		// Close parenthesis with an operator stacked but no open parenthesis.
		send_token(i2p_pkg::TK_OPERATOR, 16'h0000, OP_ADD);
		send_token(i2p_pkg::TK_CLOSE, 16'h0000, OP_ADD);
		// Unused token kinds above the end mark are ignored.
		for (int k = int'(i2p_pkg::TK_END) + 1; k < 8; k++)
			send_token(3'(k), 16'hFFFF, OP_DIV);
		// Fill the stack, overflow with an open and an operator, then flush it all.
		repeat (STACK_DEPTH - 1) send_token(i2p_pkg::TK_OPEN, 16'h0000, OP_ADD);
		send_token(i2p_pkg::TK_OPERATOR, 16'h0000, OP_ADD);
		send_token(i2p_pkg::TK_OPEN, 16'h0000, OP_ADD);
		send_token(i2p_pkg::TK_OPERATOR, 16'h0000, OP_MUL);
		send_token(i2p_pkg::TK_END, 16'h0000, OP_ADD);

		// Random expressions under each idling mix.
		foreach (sender_idle[p]) begin
			send_idle_pct = sender_idle[p];
			stall_pct = receiver_stall[p];
			send_expressions(PHASE_TOKENS);
		end

		// Long output hold-off while operands keep coming, so the input side backs up.
		send_idle_pct = 0;
		stall_pct = 0;
		hold_armed = 1'b1;
		repeat (HOLD_TOKENS)
			send_token(i2p_pkg::TK_OPERAND, 16'($urandom_range(65535)), OP_ADD);
		send_token(i2p_pkg::TK_END, 16'($urandom_range(65535)), OP_ADD);
		in_valid <= 1'b0;

		do
			@(negedge clk);
		while (pending_beats != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run sent %0d tokens under four idle/stall mixes and one long output hold-off.",
			token_count);
		$display("Checked %0d postfix beats, %0d of them errors; operator stack reached %0d of %0d.",
			beat_count, error_beats, deepest_stack, STACK_DEPTH);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
